[sv/bmp_stream_pixel_decoder_core_defines.svh]
// Assertion macros shared by the BMP decoder RTL
`ifndef BMP_STREAM_PIXEL_DECODER_CORE_DEFINES_SVH
`define BMP_STREAM_PIXEL_DECODER_CORE_DEFINES_SVH

// consequence must hold at every edge out of reset where the antecedent holds
`define BMPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define BMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bmpd_pkg.sv]
// Types and constants of the BMP stream pixel decoder
package bmpd_pkg;

   // result kinds
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_SHORT_HDR = 3'd1;
   localparam logic [2:0] ERR_SIGNATURE = 3'd2;
   localparam logic [2:0] ERR_COMPRESS  = 3'd3;
   localparam logic [2:0] ERR_DEPTH     = 3'd4;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd5;
   localparam logic [2:0] ERR_OVERLAP   = 3'd6;
   localparam logic [2:0] ERR_TRUNCATED = 3'd7;

   // depth codes
   localparam logic [1:0] DEPTH_1  = 2'd0;
   localparam logic [1:0] DEPTH_4  = 2'd1;
   localparam logic [1:0] DEPTH_8  = 2'd2;
   localparam logic [1:0] DEPTH_24 = 2'd3;

   // header layout
   localparam logic [31:0] HDR_LEN      = 32'd54;
   localparam logic [31:0] POS_SIG      = 32'd1;
   localparam logic [31:0] POS_OFFSET   = 32'd13;
   localparam logic [31:0] POS_WIDTH    = 32'd21;
   localparam logic [31:0] POS_HEIGHT   = 32'd25;
   localparam logic [31:0] POS_DEPTH    = 32'd29;
   localparam logic [31:0] POS_COMPRESS = 32'd33;
   localparam logic [15:0] SIG_BM       = 16'h4D42;

   // configuration register indexes
   localparam logic CSR_ORIGIN_X = 1'b0;
   localparam logic CSR_ORIGIN_Y = 1'b1;

   localparam int COORD_W = 13;

   // work produced by one accepted byte
   typedef struct packed {
      logic                 wr_en;
      logic [7:0]           wr_addr;
      logic [23:0]          wr_data;
      logic [3:0]           npix;
      logic                 direct;
      logic [23:0]          rgb;
      logic [7:0]           pix_byte;
      logic [1:0]           depth;
      logic [COORD_W-1:0]   x0;
      logic [COORD_W-1:0]   y;
      logic                 tail_en;
      logic [1:0]           tail_kind;
      logic [2:0]           tail_code;
   } job_type;

   // one result waiting on the palette read
   typedef struct packed {
      logic                 is_pix;
      logic [1:0]           kind;
      logic [2:0]           code;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic                 direct;
      logic [23:0]          rgb;
      logic                 in_range;
      logic                 last;
   } slot_type;

endpackage

[sv/bmpd_req_if.sv]
// Byte input channel of the BMP decoder
interface bmpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;

   modport source (output valid, file_byte, end_of_file, input ready);
   modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

[sv/bmpd_rsp_if.sv]
// Result channel of the BMP decoder
interface bmpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  error_code;
   logic [12:0] pixel_x;
   logic [12:0] pixel_y;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic        last_of_run;

   modport source (output valid, kind, error_code, pixel_x, pixel_y, red, green, blue,
                   alpha, last_of_run, input ready);
   modport sink (input valid, kind, error_code, pixel_x, pixel_y, red, green, blue,
                 alpha, last_of_run, output ready);
endinterface

[sv/bmpd_parse.sv]
// Byte parser: header, color table, skip and pixel data state of the decoder
module bmpd_parse
   import bmpd_pkg::*;
#(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_HEIGHT      = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  logic [7:0]    file_byte,
   input  logic          end_of_file,
   input  logic [11:0]   origin_x,
   input  logic [11:0]   origin_y,
   output job_type       job,
   output logic          job_push
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RBW = $clog2(3 * MAX_WIDTH + 5);
   localparam int PW  = $clog2(24 * MAX_WIDTH + 32) + 1;
   localparam int CW  = WW + 4;

   typedef enum logic [2:0] {
      PH_HEADER, PH_TABLE, PH_SKIP, PH_DATA, PH_DONE, PH_ERROR
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [31:0]      pos_ff, pos_in;
   logic [31:0]      hs_ff, hs_in;
   logic [31:0]      ds_ff, ds_in;
   logic [WW-1:0]    width_ff, width_in;
   logic [HW-1:0]    height_ff, height_in;
   logic             bu_ff, bu_in;
   logic [1:0]       depth_ff, depth_in;
   logic [HW-1:0]    row_ff, row_in;
   logic [WW-1:0]    col_ff, col_in;
   logic [RBW-1:0]   rbc_ff, rbc_in;
   logic [15:0]      pt_ff, pt_in;
   logic [1:0]       sub_ff, sub_in;
   logic             err_ff, err_in;
   logic             size_bad_ff, size_bad_in;
   logic             depth_bad_ff, depth_bad_in;
   logic [7:0]       pal_b_ff, pal_b_in;
   logic [7:0]       pal_g_ff, pal_g_in;
   logic [RBW-1:0]   row_bytes_ff, row_bytes_in;

   logic [31:0]      sh;
   logic [31:0]      mag;
   logic [31:0]      pal_off;
   logic [31:0]      tbl_len;
   logic [PW-1:0]    bits_w;
   logic [PW-1:0]    rb_wide;
   logic [HW-1:0]    line;
   logic [CW-1:0]    avail;
   logic [3:0]       ppb;
   logic [3:0]       npix;
   logic [RBW-1:0]   rbc_next;

   // row length in bytes, padded to 4
   always_comb begin
      case (depth_ff)
         DEPTH_1: bits_w = PW'(width_ff);
         DEPTH_4: bits_w = PW'(width_ff) << 2;
         DEPTH_8: bits_w = PW'(width_ff) << 3;
         default: bits_w = (PW'(width_ff) << 4) + (PW'(width_ff) << 3);
      endcase
      rb_wide      = ((bits_w + PW'(31)) >> 5) << 2;
      row_bytes_in = RBW'(rb_wide);
   end

   // color table length for the current depth
   always_comb begin
      case (depth_ff)
         DEPTH_1: tbl_len = 32'd8;
         DEPTH_4: tbl_len = 32'd64;
         DEPTH_8: tbl_len = 32'd1024;
         default: tbl_len = 32'd0;
      endcase
   end

   // pixels carried by one data byte
   always_comb begin
      case (depth_ff)
         DEPTH_1: ppb = 4'd8;
         DEPTH_4: ppb = 4'd2;
         default: ppb = 4'd1;
      endcase
   end

   assign sh      = {file_byte, hs_ff[31:8]};
   assign mag     = sh[31] ? (32'd0 - sh) : sh;
   assign pal_off = pos_ff - HDR_LEN;
   assign avail   = CW'(width_ff - col_ff);
   assign line    = bu_ff ? (height_ff - HW'(1) - row_ff) : row_ff;

   // next state and the job for this byte
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      hs_in        = hs_ff;
      ds_in        = ds_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      bu_in        = bu_ff;
      depth_in     = depth_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rbc_in       = rbc_ff;
      pt_in        = pt_ff;
      sub_in       = sub_ff;
      err_in       = err_ff;
      size_bad_in  = size_bad_ff;
      depth_bad_in = depth_bad_ff;
      pal_b_in     = pal_b_ff;
      pal_g_in     = pal_g_ff;
      npix         = 4'd0;
      rbc_next     = rbc_ff + RBW'(1);

      job          = '0;
      job.pix_byte = file_byte;
      job.depth    = depth_ff;
      job.x0       = COORD_W'(origin_x) + COORD_W'(col_ff);
      job.y        = COORD_W'(origin_y) + COORD_W'(line);

      unique case (phase_ff)
         PH_HEADER: begin
            hs_in = sh;
            if (pos_ff == POS_SIG) begin
               if (sh[31:16] != SIG_BM) begin
                  job.tail_en   = 1'b1;
                  job.tail_kind = KIND_ERROR;
                  job.tail_code = ERR_SIGNATURE;
                  phase_in      = PH_ERROR;
                  err_in        = 1'b1;
               end
            end else if (pos_ff == POS_OFFSET) begin
               ds_in = sh;
            end else if (pos_ff == POS_WIDTH) begin
               if (sh > 32'(MAX_WIDTH)) size_bad_in = 1'b1;
               else width_in = WW'(sh);
            end else if (pos_ff == POS_HEIGHT) begin
               bu_in = !sh[31] && (sh != 32'd0);
               if (mag > 32'(MAX_HEIGHT)) size_bad_in = 1'b1;
               else height_in = HW'(mag);
            end else if (pos_ff == POS_DEPTH) begin
               case (sh[31:16])
                  16'd1:   depth_in = DEPTH_1;
                  16'd4:   depth_in = DEPTH_4;
                  16'd8:   depth_in = DEPTH_8;
                  16'd24:  depth_in = DEPTH_24;
                  default: depth_bad_in = 1'b1;
               endcase
            end else if (pos_ff == POS_COMPRESS) begin
               job.tail_kind = KIND_ERROR;
               if (sh != 32'd0) begin
                  job.tail_en   = 1'b1;
                  job.tail_code = ERR_COMPRESS;
               end else if (depth_bad_ff) begin
                  job.tail_en   = 1'b1;
                  job.tail_code = ERR_DEPTH;
               end else if (size_bad_ff) begin
                  job.tail_en   = 1'b1;
                  job.tail_code = ERR_TOO_LARGE;
               end else if (ds_ff < HDR_LEN + tbl_len) begin
                  job.tail_en   = 1'b1;
                  job.tail_code = ERR_OVERLAP;
               end
               if (job.tail_en) begin
                  phase_in = PH_ERROR;
                  err_in   = 1'b1;
               end
            end
            pos_in = pos_ff + 32'd1;
            if (phase_in == PH_HEADER && pos_in >= HDR_LEN) phase_in = PH_TABLE;
         end
         PH_TABLE: begin
            // BGRx entries: collect blue and green, write the entry on red
            if (pal_off[31:2] < 30'(PALETTE_ENTRIES)) begin
               case (pal_off[1:0])
                  2'd0: pal_b_in = file_byte;
                  2'd1: pal_g_in = file_byte;
                  2'd2: begin
                     job.wr_en   = 1'b1;
                     job.wr_addr = pal_off[9:2];
                     job.wr_data = {file_byte, pal_g_ff, pal_b_ff};
                  end
                  default: ;
               endcase
            end
            pos_in = pos_ff + 32'd1;
         end
         PH_SKIP: begin
            pos_in = pos_ff + 32'd1;
         end
         PH_DATA: begin
            if (col_ff < width_ff) begin
               if (depth_ff == DEPTH_24) begin
                  case (sub_ff)
                     2'd0: begin
                        pt_in  = {8'h00, file_byte};
                        sub_in = 2'd1;
                     end
                     2'd1: begin
                        pt_in  = {file_byte, pt_ff[7:0]};
                        sub_in = 2'd2;
                     end
                     default: begin
                        npix       = 4'd1;
                        job.direct = 1'b1;
                        job.rgb    = {file_byte, pt_ff};
                        sub_in     = 2'd0;
                     end
                  endcase
               end else begin
                  npix = (avail < CW'(ppb)) ? 4'(avail) : ppb;
               end
            end
            job.npix = npix;
            col_in   = col_ff + WW'(npix);
            // row end drops the padding and advances the line
            if (rbc_next >= row_bytes_ff) begin
               rbc_in = '0;
               col_in = '0;
               sub_in = 2'd0;
               row_in = row_ff + HW'(1);
               if (row_in >= height_ff) begin
                  job.tail_en   = 1'b1;
                  job.tail_kind = KIND_DONE;
                  job.tail_code = ERR_NONE;
                  phase_in      = PH_DONE;
               end
            end else begin
               rbc_in = rbc_next;
            end
         end
         default: ;
      endcase

      // phase steps that follow the byte count
      if (phase_in == PH_TABLE && pos_in >= HDR_LEN + tbl_len) phase_in = PH_SKIP;
      if (phase_in == PH_SKIP && pos_in >= ds_ff) begin
         phase_in = PH_DATA;
         if (width_ff == '0 || height_ff == '0) begin
            job.tail_en   = 1'b1;
            job.tail_kind = KIND_DONE;
            job.tail_code = ERR_NONE;
            phase_in      = PH_DONE;
         end
      end

      // end of file: flag an unfinished image, then start over
      if (end_of_file) begin
         if (phase_in != PH_DONE && phase_in != PH_ERROR && !err_in) begin
            job.tail_en   = 1'b1;
            job.tail_kind = KIND_ERROR;
            job.tail_code = (phase_in == PH_HEADER) ? ERR_SHORT_HDR : ERR_TRUNCATED;
         end
         phase_in     = PH_HEADER;
         pos_in       = '0;
         hs_in        = '0;
         ds_in        = '0;
         width_in     = '0;
         height_in    = '0;
         bu_in        = 1'b0;
         depth_in     = DEPTH_1;
         row_in       = '0;
         col_in       = '0;
         rbc_in       = '0;
         pt_in        = '0;
         sub_in       = 2'd0;
         err_in       = 1'b0;
         size_bad_in  = 1'b0;
         depth_bad_in = 1'b0;
      end
   end

   assign job_push = fire && (job.npix != 4'd0 || job.tail_en || job.wr_en);

   // parser state
   always_ff @(posedge clock) begin
      row_bytes_ff <= row_bytes_in;
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         hs_ff        <= '0;
         ds_ff        <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         bu_ff        <= 1'b0;
         depth_ff     <= DEPTH_1;
         row_ff       <= '0;
         col_ff       <= '0;
         rbc_ff       <= '0;
         pt_ff        <= '0;
         sub_ff       <= 2'd0;
         err_ff       <= 1'b0;
         size_bad_ff  <= 1'b0;
         depth_bad_ff <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         hs_ff        <= hs_in;
         ds_ff        <= ds_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bu_ff        <= bu_in;
         depth_ff     <= depth_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rbc_ff       <= rbc_in;
         pt_ff        <= pt_in;
         sub_ff       <= sub_in;
         err_ff       <= err_in;
         size_bad_ff  <= size_bad_in;
         depth_bad_ff <= depth_bad_in;
         pal_b_ff     <= pal_b_in;
         pal_g_ff     <= pal_g_in;
      end
   end

endmodule

[sv/bmp_stream_pixel_decoder_core.sv]
// Top level of the streaming BMP pixel decoder
//
//   channel   dir   payload                                      accept
//   req_bus   in    file_byte, end_of_file                       valid & ready
//   rsp_bus   out   kind, error_code, pixel_x/y, r/g/b/a, last   valid & ready
//   csr_*     in    csr_index, csr_wdata (origin_x, origin_y)    csr_we
//
// One byte per cycle while each byte yields at most one result and the result
// output is not stalled; a byte that yields n results keeps req ready low until
// its last result slot issues, set by the single result slot per cycle feeding
// the palette memory read port. The first result of a byte is valid once it has
// passed the job, palette read and output registers.
// Reset is synchronous; the palette memory is not cleared.
// A stalled result output freezes the whole result pipeline.
`include "bmp_stream_pixel_decoder_core_defines.svh"
module bmp_stream_pixel_decoder_core
   import bmpd_pkg::*;
#(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_HEIGHT      = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   bmpd_req_if.sink      req_bus,
   bmpd_rsp_if.source    rsp_bus,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [11:0]   csr_wdata
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [11:0]      origin_x_ff;
   logic [11:0]      origin_y_ff;

   job_type          job_next;
   logic             job_push;
   job_type          job_ff;
   logic             job_valid_ff;
   logic [3:0]       k_ff;
   logic [3:0]       nres;
   logic             slot_last;
   logic             job_done;
   logic             adv;
   logic             fire;
   logic             issue;

   logic [23:0]      pal_mem [PALETTE_ENTRIES];
   logic [23:0]      mem_q;
   logic [7:0]       pal_idx;

   slot_type         slot;
   slot_type         c_ff;
   logic             c_valid_ff;

   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [2:0]       rsp_code_ff;
   logic [12:0]      rsp_x_ff;
   logic [12:0]      rsp_y_ff;
   logic [23:0]      rsp_rgb_ff;
   logic [7:0]       rsp_alpha_ff;
   logic             rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   bmpd_parse #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .file_byte   (req_bus.file_byte),
      .end_of_file (req_bus.end_of_file),
      .origin_x    (origin_x_ff),
      .origin_y    (origin_y_ff),
      .job         (job_next),
      .job_push    (job_push)
   );

   // job handshake: results of a job leave one per beat
   assign adv       = !rsp_valid_ff || rsp_bus.ready;
   assign nres      = job_ff.npix + 4'(job_ff.tail_en);
   assign slot_last = (k_ff == nres - 4'd1);
   assign job_done  = job_valid_ff && (nres == 4'd0 || (slot_last && adv));
   assign req_bus.ready = !job_valid_ff || job_done;
   assign fire      = req_bus.valid && req_bus.ready;
   assign issue     = job_valid_ff && (nres != 4'd0) && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else if (job_push) begin
         job_valid_ff <= 1'b1;
         job_ff       <= job_next;
         k_ff         <= '0;
      end else if (job_done) begin
         job_valid_ff <= 1'b0;
      end else if (issue) begin
         k_ff <= k_ff + 4'd1;
      end
   end

   // palette index of the current slot
   always_comb begin
      case (job_ff.depth)
         DEPTH_1: pal_idx = {7'd0, job_ff.pix_byte[3'd7 - k_ff[2:0]]};
         DEPTH_4: pal_idx = k_ff[0] ? {4'd0, job_ff.pix_byte[3:0]}
                                    : {4'd0, job_ff.pix_byte[7:4]};
         default: pal_idx = job_ff.pix_byte;
      endcase
   end

   always_comb begin
      slot.is_pix   = k_ff < job_ff.npix;
      slot.kind     = slot.is_pix ? KIND_PIXEL : job_ff.tail_kind;
      slot.code     = slot.is_pix ? ERR_NONE : job_ff.tail_code;
      slot.x        = slot.is_pix ? (job_ff.x0 + COORD_W'(k_ff)) : '0;
      slot.y        = slot.is_pix ? job_ff.y : '0;
      slot.direct   = job_ff.direct;
      slot.rgb      = job_ff.rgb;
      slot.in_range = {1'b0, pal_idx} < 9'(PALETTE_ENTRIES);
      slot.last     = slot_last;
   end

   // palette memory: writes and reads both pass through the job stage in order
   always_ff @(posedge clock) begin
      if (job_valid_ff && job_ff.wr_en) begin
         pal_mem[job_ff.wr_addr[AW-1:0]] <= job_ff.wr_data;
      end
      if (adv) begin
         mem_q <= pal_mem[pal_idx[AW-1:0]];
      end
   end

   // read stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff   <= issue;
         c_ff         <= slot;
         rsp_valid_ff <= c_valid_ff;
         rsp_kind_ff  <= c_ff.kind;
         rsp_code_ff  <= c_ff.code;
         rsp_x_ff     <= c_ff.x;
         rsp_y_ff     <= c_ff.y;
         rsp_last_ff  <= c_ff.last;
         rsp_alpha_ff <= c_ff.is_pix ? 8'hFF : 8'h00;
         if (!c_ff.is_pix) rsp_rgb_ff <= '0;
         else if (c_ff.direct) rsp_rgb_ff <= c_ff.rgb;
         else if (c_ff.in_range) rsp_rgb_ff <= mem_q;
         else rsp_rgb_ff <= '0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.error_code  = rsp_code_ff;
   assign rsp_bus.pixel_x     = rsp_x_ff;
   assign rsp_bus.pixel_y     = rsp_y_ff;
   assign rsp_bus.red         = rsp_rgb_ff[23:16];
   assign rsp_bus.green       = rsp_rgb_ff[15:8];
   assign rsp_bus.blue        = rsp_rgb_ff[7:0];
   assign rsp_bus.alpha       = rsp_alpha_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   `BMPD_ASSERT_IMPLY(a_slot_range, job_valid_ff && nres != 4'd0, k_ff < nres, "slot past job end")
   `BMPD_ASSERT_IMPLY(a_npix_max, job_valid_ff, job_ff.npix <= 4'd8, "too many pixels in job")
   `BMPD_ASSERT_IMPLY(a_tail_last, rsp_valid_ff && rsp_kind_ff != KIND_PIXEL, rsp_last_ff, "status beat not last")
   `BMPD_ASSERT_NEXT(a_stall_hold, c_valid_ff && !adv, c_valid_ff && $stable(c_ff), "read stage lost on stall")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the streaming BMP pixel decoder
`timescale 1ns / 1ps

module tb_top;
   import bmpd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_GAP   = 12;

   // decoder stream phases
   typedef enum int {PH_HEADER, PH_TABLE, PH_SKIP, PH_DATA, PH_DONE, PH_ERROR} dec_phase_type;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  code;
      logic [12:0] x;
      logic [12:0] y;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a;
      logic        last;
   } pixel_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [11:0] csr_wdata;

   bmpd_req_if req_bus();
   bmpd_rsp_if rsp_bus();

   bmp_stream_pixel_decoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_result_type want_q[$];
   logic [7:0]    file_q[$];
   int            errors;
   int            cycles;
   int            beats_out;
   int            bytes_sent;
   bit            idle_on;
   bit            hold_req;

   // shadow of the decoder state
   int unsigned   org_x, org_y;
   int unsigned   byte_pos, hdr_shift, data_start, img_w, img_h;
   int unsigned   bottom_up, depth_sel, row_cnt, col_cnt, row_byte_cnt, partial;
   int unsigned   palette [256];
   dec_phase_type phase;
   bit            err_latched, size_bad, depth_bad;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic int unsigned depth_bits(int unsigned d);
      case (d)
         DEPTH_1: return 1;
         DEPTH_4: return 4;
         DEPTH_8: return 8;
         default: return 24;
      endcase
   endfunction

   function automatic int unsigned pal_bytes();
      return depth_sel < DEPTH_24 ? (4 << depth_bits(depth_sel)) : 0;
   endfunction

   function automatic int unsigned row_len();
      return ((depth_bits(depth_sel) * img_w + 31) / 32) * 4;
   endfunction

   function automatic void clear_stream();
      byte_pos = 0; hdr_shift = 0; data_start = 0; img_w = 0; img_h = 0;
      bottom_up = 0; depth_sel = DEPTH_1; row_cnt = 0; col_cnt = 0;
      row_byte_cnt = 0; partial = 0; phase = PH_HEADER;
      err_latched = 0; size_bad = 0; depth_bad = 0;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [2:0] code,
                                       int unsigned x, int unsigned y,
                                       int unsigned rgb, logic [7:0] a);
      pixel_result_type e;
      e.kind = kind; e.code = code; e.x = x[12:0]; e.y = y[12:0];
      e.r = rgb[23:16]; e.g = rgb[15:8]; e.b = rgb[7:0]; e.a = a; e.last = 0;
      want_q.push_back(e);
   endfunction

   function automatic void fail_stream(logic [2:0] code);
      push_result(KIND_ERROR, code, 0, 0, 0, 0);
      phase = PH_ERROR;
      err_latched = 1;
   endfunction

   function automatic void emit_pixel(int unsigned rgb);
      int unsigned line;
      line = bottom_up ? img_h - 1 - row_cnt : row_cnt;
      push_result(KIND_PIXEL, ERR_NONE, org_x + col_cnt, org_y + line, rgb, 8'hFF);
      col_cnt++;
   endfunction

   function automatic int unsigned pal_color(int unsigned idx);
      return idx < 256 ? (palette[idx] & 32'hFFFFFF) : 0;
   endfunction

   function automatic void header_byte(logic [7:0] b);
      int unsigned mag;
      int unsigned bpp;
      hdr_shift = {b, hdr_shift[31:8]};
      if (byte_pos == POS_SIG) begin
         if (hdr_shift[31:16] != SIG_BM) fail_stream(ERR_SIGNATURE);
      end else if (byte_pos == POS_OFFSET) begin
         data_start = hdr_shift;
      end else if (byte_pos == POS_WIDTH) begin
         if (hdr_shift > 4096) size_bad = 1;
         else img_w = hdr_shift;
      end else if (byte_pos == POS_HEIGHT) begin
         if (hdr_shift[31]) begin
            mag = 0 - hdr_shift; bottom_up = 0;
         end else begin
            mag = hdr_shift; bottom_up = (hdr_shift != 0);
         end
         if (mag > 4096) size_bad = 1;
         else img_h = mag;
      end else if (byte_pos == POS_DEPTH) begin
         bpp = hdr_shift >> 16;
         if (bpp == 1) depth_sel = DEPTH_1;
         else if (bpp == 4) depth_sel = DEPTH_4;
         else if (bpp == 8) depth_sel = DEPTH_8;
         else if (bpp == 24) depth_sel = DEPTH_24;
         else depth_bad = 1;
      end else if (byte_pos == POS_COMPRESS) begin
         if (hdr_shift != 0) fail_stream(ERR_COMPRESS);
         else if (depth_bad) fail_stream(ERR_DEPTH);
         else if (size_bad) fail_stream(ERR_TOO_LARGE);
         else if (data_start < HDR_LEN + pal_bytes()) fail_stream(ERR_OVERLAP);
      end
      byte_pos++;
      if (phase == PH_HEADER && byte_pos >= HDR_LEN) phase = PH_TABLE;
   endfunction

   function automatic void data_byte(logic [7:0] b);
      int unsigned sub;
      if (depth_sel == DEPTH_24) begin
         if (col_cnt < img_w) begin
            sub = row_byte_cnt - 3 * col_cnt;
            if (sub == 0) partial = b;
            else if (sub == 1) partial = (partial & 32'hFF) | (b << 8);
            else emit_pixel((b << 16) | (partial & 32'hFFFF));
         end
      end else if (depth_sel == DEPTH_8) begin
         if (col_cnt < img_w) emit_pixel(pal_color(b));
      end else if (depth_sel == DEPTH_4) begin
         for (int k = 0; k < 2; k++)
            if (col_cnt < img_w) emit_pixel(pal_color((b >> (4 - 4 * k)) & 4'hF));
      end else begin
         for (int k = 0; k < 8; k++)
            if (col_cnt < img_w) emit_pixel(pal_color((b >> (7 - k)) & 1));
      end
      row_byte_cnt++;
      if (row_byte_cnt >= row_len()) begin
         row_byte_cnt = 0;
         col_cnt = 0;
         row_cnt++;
         if (row_cnt >= img_h) begin
            push_result(KIND_DONE, ERR_NONE, 0, 0, 0, 0);
            phase = PH_DONE;
         end
      end
   endfunction

   // expected results of one accepted byte
   function automatic void predict_byte(logic [7:0] b, logic eof);
      int n0;
      int unsigned off;
      n0 = want_q.size();
      case (phase)
         PH_HEADER: header_byte(b);
         PH_TABLE: begin
            off = byte_pos - HDR_LEN;
            if ((off >> 2) < 256 && (off & 3) < 3)
               palette[off >> 2][8 * (off & 3) +: 8] = b;
            byte_pos++;
         end
         PH_SKIP: byte_pos++;
         PH_DATA: data_byte(b);
         default: ;
      endcase
      if (phase == PH_TABLE && byte_pos >= HDR_LEN + pal_bytes()) phase = PH_SKIP;
      if (phase == PH_SKIP && byte_pos >= data_start) begin
         phase = PH_DATA;
         if (img_w == 0 || img_h == 0) begin
            push_result(KIND_DONE, ERR_NONE, 0, 0, 0, 0);
            phase = PH_DONE;
         end
      end
      if (eof) begin
         if (phase != PH_DONE && phase != PH_ERROR && !err_latched)
            fail_stream(phase == PH_HEADER ? ERR_SHORT_HDR : ERR_TRUNCATED);
         clear_stream();
      end
      if (want_q.size() > n0) want_q[want_q.size() - 1].last = 1;
   endfunction

   // ---------------- result checking ----------------
   task automatic report(string field, int got, int want);
      $display("mismatch on result beat %0d: %s got %0d expected %0d",
               beats_out, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      pixel_result_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (want_q.size() == 0) begin
            report("unexpected beat, kind", rsp_bus.kind, -1);
         end else begin
            e = want_q.pop_front();
            if (rsp_bus.kind !== e.kind) report("kind", rsp_bus.kind, e.kind);
            if (rsp_bus.error_code !== e.code) report("error_code", rsp_bus.error_code, e.code);
            if (rsp_bus.pixel_x !== e.x) report("pixel_x", rsp_bus.pixel_x, e.x);
            if (rsp_bus.pixel_y !== e.y) report("pixel_y", rsp_bus.pixel_y, e.y);
            if (rsp_bus.red !== e.r) report("red", rsp_bus.red, e.r);
            if (rsp_bus.green !== e.g) report("green", rsp_bus.green, e.g);
            if (rsp_bus.blue !== e.b) report("blue", rsp_bus.blue, e.b);
            if (rsp_bus.alpha !== e.a) report("alpha", rsp_bus.alpha, e.a);
            if (rsp_bus.last_of_run !== e.last)
               report("last_of_run", rsp_bus.last_of_run, e.last);
         end
         beats_out++;
      end
   end

   // receiver: random stall bursts plus a long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_bus.ready = 0;
         end else begin
            rsp_bus.ready = 1;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_byte(logic [7:0] b, logic eof);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 0;
         end
      end
      @(negedge clock);
      req_bus.valid = 1;
      req_bus.file_byte = b;
      req_bus.end_of_file = eof;
      do @(posedge clock); while (!req_bus.ready);
      predict_byte(b, eof);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++)
         send_byte(file_q[i], i == file_q.size() - 1);
      @(negedge clock);
      req_bus.valid = 0;
   endtask

   function automatic void put32(int pos, int unsigned v);
      for (int i = 0; i < 4; i++) file_q[pos + i] = v[8 * i +: 8];
   endfunction

   // builds a file; keep >= 0 cuts it short, tail adds bytes after the image
   function automatic void build_file(int w, int hgt, int bpp, int comp, int gap,
                                      bit sig_ok, int keep, int tail);
      int unsigned pal, rows, rb, mag;
      bit ok;
      file_q.delete();
      for (int i = 0; i < 54; i++) file_q.push_back($urandom_range(0, 255));
      file_q[0] = sig_ok ? 8'h42 : 8'h43;
      file_q[1] = 8'h4D;
      pal = (bpp == 1) ? 8 : (bpp == 4) ? 64 : (bpp == 8) ? 1024 : 0;
      put32(10, 54 + pal + gap);
      put32(18, w);
      put32(22, hgt);
      put32(26, (bpp << 16) | 1);
      put32(30, comp);
      mag = hgt < 0 ? -hgt : hgt;
      ok = (bpp == 1 || bpp == 4 || bpp == 8 || bpp == 24) && comp == 0 && sig_ok &&
           w >= 0 && w <= 4096 && mag <= 4096 && gap >= 0;
      if (ok) begin
         rows = mag;
         rb = ((bpp * w + 31) / 32) * 4;
         repeat (pal + gap + rows * rb) file_q.push_back($urandom_range(0, 255));
      end else begin
         repeat (4) file_q.push_back($urandom_range(0, 255));
      end
      if (keep >= 0 && keep < file_q.size()) file_q = file_q[0:keep - 1];
      repeat (tail) file_q.push_back($urandom_range(0, 255));
   endfunction

   task automatic wait_idle();
      while (want_q.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_origin(logic [11:0] ox, logic [11:0] oy);
      wait_idle();
      @(negedge clock);
      csr_we = 1; csr_index = CSR_ORIGIN_X; csr_wdata = ox;
      @(negedge clock);
      csr_index = CSR_ORIGIN_Y; csr_wdata = oy;
      @(posedge clock);
      org_x = ox;
      org_y = oy;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic test_depths();
      build_file(9, 2, 1, 0, 0, 1, -1, 0);   send_file();
      build_file(5, -3, 4, 0, 2, 1, -1, 0);  send_file();
      build_file(3, 2, 8, 0, 0, 1, -1, 0);   send_file();
      build_file(4, 3, 24, 0, 1, 1, -1, 3);  send_file();
      build_file(0, 2, 24, 0, 0, 1, -1, 2);  send_file();
      build_file(3, 0, 1, 0, 0, 1, -1, 0);   send_file();
   endtask

   task automatic test_header_errors();
      build_file(2, 2, 24, 0, 0, 0, -1, 0);    send_file();
      build_file(2, 2, 24, 1, 0, 1, -1, 0);    send_file();
      build_file(2, 2, 16, 0, 0, 1, -1, 0);    send_file();
      build_file(5000, 2, 24, 0, 0, 1, -1, 0); send_file();
      build_file(-3, 2, 24, 0, 0, 1, -1, 0);   send_file();
      build_file(2, -5000, 24, 0, 0, 1, -1, 0); send_file();
      build_file(2, 2, 4, 0, -1, 1, -1, 0);    send_file();
      build_file(2, 2, 24, 0, 0, 1, 30, 0);    send_file();
      build_file(3, 2, 24, 0, 0, 1, 60, 0);    send_file();
      build_file(3, 2, 1, 0, 0, 1, 58, 0);     send_file();
   endtask

   task automatic test_origins();
      write_origin(12'd4095, 12'd4095);
      build_file(4, 3, 1, 0, 0, 1, -1, 0); send_file();
      write_origin(12'd0, 12'd4095);
      build_file(3, -2, 24, 0, 0, 1, -1, 0); send_file();
      write_origin(12'd4095, 12'd0);
      build_file(6, 2, 4, 0, 0, 1, -1, 0); send_file();
      write_origin(12'd1234, 12'd2730);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_req = 1;
      build_file(24, 3, 1, 0, 0, 1, -1, 0);
      send_file();
      wait_idle();
   endtask

   task automatic random_file();
      int pick, bpp, keep;
      pick = $urandom_range(0, 9);
      keep = -1;
      if (pick < 8) begin
         case ($urandom_range(0, 9))
            0, 1, 2: bpp = 1;
            3, 4, 5: bpp = 4;
            default: bpp = 24;
         endcase
         build_file($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 9),
                    $urandom_range(0, 6) - 3, bpp, 0, $urandom_range(0, 3), 1, -1,
                    $urandom_range(0, 2));
         if ($urandom_range(0, 7) == 0) file_q = file_q[0:$urandom_range(1, file_q.size()) - 1];
      end else if (pick == 8) begin
         build_file($urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(0, 30),
                    $urandom_range(0, 1), $urandom_range(0, 4) - 1, $urandom_range(0, 5) != 0,
                    keep, 0);
      end else begin
         file_q.delete();
         repeat ($urandom_range(1, 40)) file_q.push_back($urandom_range(0, 255));
      end
      send_file();
   endtask

   task automatic test_random(int target);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < target) random_file();
   endtask

   initial begin
      clock = 0;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_ORIGIN_X;
      csr_wdata = 0;
      req_bus.valid = 0;
      req_bus.file_byte = 0;
      req_bus.end_of_file = 0;
      errors = 0;
      cycles = 0;
      beats_out = 0;
      bytes_sent = 0;
      idle_on = 1;
      hold_req = 0;
      org_x = 0;
      org_y = 0;
      foreach (palette[i]) palette[i] = 0;
      clear_stream();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_depths();
      test_header_errors();
      test_origins();
      test_backpressure();
      test_random(100);
      idle_on = 0;
      test_random(60);

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[bmp_stream_pixel_decoder_core.f]
+incdir+sv
sv/bmpd_pkg.sv
sv/bmpd_req_if.sv
sv/bmpd_rsp_if.sv
sv/bmpd_parse.sv
sv/bmp_stream_pixel_decoder_core.sv
tb/tb_top.sv
